### sv/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/macd_pkg.sv
`default_nettype none

package macd_pkg;

  localparam int REG_W      = 17;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int ALPHA_BITS = 16;

  localparam logic [1:0] REG_IDX_SHORT  = 2'd0;
  localparam logic [1:0] REG_IDX_LONG   = 2'd1;
  localparam logic [1:0] REG_IDX_SIGNAL = 2'd2;

  localparam logic [REG_W-1:0] SHORT_ALPHA_RST  = 17'd10082;
  localparam logic [REG_W-1:0] LONG_ALPHA_RST   = 17'd4855;
  localparam logic [REG_W-1:0] SIGNAL_ALPHA_RST = 17'd13107;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_BUY  = 2'd1,
    MARK_SELL = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    MUL_SHORT  = 2'd0,
    MUL_LONG   = 2'd1,
    MUL_SIGNAL = 2'd2
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL_SHORT,
    ST_MUL_LONG,
    ST_ADD_LONG,
    ST_MUL_SIGNAL,
    ST_ADD_SIGNAL
  } macd_state_e;

  typedef struct packed {
    logic     load_in;
    logic     seed;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_short;
    logic     upd_long;
    logic     upd_signal;
    logic     load_out;
  } macd_cmd_t;

  typedef struct packed {
    logic seeded;
    logic out_free;
  } macd_sts_t;

endpackage

`default_nettype wire

### sv/macd_in_if.sv
`default_nettype none

interface macd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  logic        series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);
endinterface

`default_nettype wire

### sv/macd_out_if.sv
`default_nettype none

interface macd_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] macd_value;
  logic signed [32:0] signal_value;
  logic               buy_mark;
  logic               sell_mark;

  modport source (output valid, output macd_value, output signal_value,
                  output buy_mark, output sell_mark, input ready);
  modport sink   (input valid, input macd_value, input signal_value,
                  input buy_mark, input sell_mark, output ready);
endinterface

`default_nettype wire

### sv/macd_crossover_signal.sv
// MACD crossover signal (12/26/9 by default).
// Input transfer: price (unsigned Q16.16) and series_start. Output transfer:
// macd_value and signal_value (signed Q16.16), buy_mark and sell_mark.
// EMA weights are Q1.16 registers on the APB port at byte 0, 4 and 8
// (short, long, signal); write them only while no sample is in flight.
// A seeding sample (series_start, or the first after reset) goes through
// the seed step, which seeds the EMAs and loads the output register; any
// other sample goes through ST_MUL_SHORT, ST_MUL_LONG, ST_ADD_LONG,
// ST_MUL_SIGNAL and ST_ADD_SIGNAL, as its three EMA updates share one
// multiplier, each a multiply step and an accumulate step, with the long and
// short steps overlapped. One sample is in flight at a time; the next is
// taken only once the last reaches the output register, where it sits; the
// next sample is taken while it waits. If the receiver stalls, the following
// sample waits at its last step until the output register frees, then input ready rises again.
// Reset restores the default weights and clears the seeded flag; the next
// sample reseeds all three EMAs and gives no mark.
`default_nettype none

module macd_crossover_signal import macd_pkg::*; #(
  parameter int AVERAGE_FRAC_BITS = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  macd_in_if.sink                in_if,
  macd_out_if.source             out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

`include "assert_macros.svh"

  logic [REG_W-1:0] short_alpha, long_alpha, signal_alpha;
  macd_cmd_t        cmd;
  macd_sts_t        sts;

  macd_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready),
    .short_alpha_o  (short_alpha),
    .long_alpha_o   (long_alpha),
    .signal_alpha_o (signal_alpha)
  );

  macd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .series_start_i (in_if.series_start),
    .sts_i          (sts),
    .in_ready_o     (in_if.ready),
    .cmd_o          (cmd)
  );

  macd_dp #(
    .AVERAGE_FRAC_BITS (AVERAGE_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .price_i        (in_if.price),
    .short_alpha_i  (short_alpha),
    .long_alpha_i   (long_alpha),
    .signal_alpha_i (signal_alpha),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .macd_value_o   (out_if.macd_value),
    .signal_value_o (out_if.signal_value),
    .buy_mark_o     (out_if.buy_mark),
    .sell_mark_o    (out_if.sell_mark)
  );

  `ASSERT_IMPLIES(a_load_out_free, clk_i, rst_ni, cmd.load_out, sts.out_free)
  `ASSERT_IMPLIES(a_seed_excl, clk_i, rst_ni, cmd.seed, !cmd.mul_en && !cmd.upd_signal)
  `ASSERT_NEXT(a_out_loaded, clk_i, rst_ni, cmd.load_out, out_if.valid)
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_if.valid && in_if.ready, !in_if.ready)

endmodule

`default_nettype wire

### sv/macd_cfg.sv
`default_nettype none

module macd_cfg import macd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [ADDR_W-1:0] paddr_i,
  input  wire logic [DATA_W-1:0] pwdata_i,
  output logic      [DATA_W-1:0] prdata_o,
  output logic                   pready_o,
  output logic      [REG_W-1:0]  short_alpha_o,
  output logic      [REG_W-1:0]  long_alpha_o,
  output logic      [REG_W-1:0]  signal_alpha_o
);

  logic [REG_W-1:0] short_q, short_d;
  logic [REG_W-1:0] long_q, long_d;
  logic [REG_W-1:0] signal_q, signal_d;
  logic [1:0]       idx;
  logic             wr;

  assign idx      = paddr_i[ADDR_W-1:2];
  assign wr       = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_comb begin
    short_d  = short_q;
    long_d   = long_q;
    signal_d = signal_q;
    if (wr) begin
      unique case (idx)
        REG_IDX_SHORT:  short_d  = pwdata_i[REG_W-1:0];
        REG_IDX_LONG:   long_d   = pwdata_i[REG_W-1:0];
        REG_IDX_SIGNAL: signal_d = pwdata_i[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IDX_SHORT:  prdata_o = DATA_W'(short_q);
      REG_IDX_LONG:   prdata_o = DATA_W'(long_q);
      REG_IDX_SIGNAL: prdata_o = DATA_W'(signal_q);
      default:        prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q  <= SHORT_ALPHA_RST;
      long_q   <= LONG_ALPHA_RST;
      signal_q <= SIGNAL_ALPHA_RST;
    end else begin
      short_q  <= short_d;
      long_q   <= long_d;
      signal_q <= signal_d;
    end
  end

  assign short_alpha_o  = short_q;
  assign long_alpha_o   = long_q;
  assign signal_alpha_o = signal_q;

endmodule

`default_nettype wire

### sv/macd_ctrl.sv
`default_nettype none

module macd_ctrl import macd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      series_start_i,
  input  wire macd_sts_t sts_i,
  output logic           in_ready_o,
  output macd_cmd_t      cmd_o
);

  macd_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (series_start_i || !sts_i.seeded) ? ST_SEED : ST_MUL_SHORT;
        end
      end
      ST_SEED: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_MUL_SHORT:  state_d = ST_MUL_LONG;
      ST_MUL_LONG:   state_d = ST_ADD_LONG;
      ST_ADD_LONG:   state_d = ST_MUL_SIGNAL;
      ST_MUL_SIGNAL: state_d = ST_ADD_SIGNAL;
      ST_ADD_SIGNAL: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_SEED: begin
        cmd_o.seed     = sts_i.out_free;
        cmd_o.load_out = sts_i.out_free;
      end
      ST_MUL_SHORT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SHORT;
      end
      ST_MUL_LONG: begin
        cmd_o.upd_short = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_LONG;
      end
      ST_ADD_LONG: begin
        cmd_o.upd_long = 1'b1;
      end
      ST_MUL_SIGNAL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SIGNAL;
      end
      ST_ADD_SIGNAL: begin
        cmd_o.upd_signal = sts_i.out_free;
        cmd_o.load_out   = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/macd_dp.sv
`default_nettype none

module macd_dp import macd_pkg::*; #(
  parameter int AVERAGE_FRAC_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire macd_cmd_t          cmd_i,
  output macd_sts_t               sts_o,
  input  wire logic [31:0]        price_i,
  input  wire logic [REG_W-1:0]   short_alpha_i,
  input  wire logic [REG_W-1:0]   long_alpha_i,
  input  wire logic [REG_W-1:0]   signal_alpha_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [32:0]      macd_value_o,
  output logic signed [32:0]      signal_value_o,
  output logic                    buy_mark_o,
  output logic                    sell_mark_o
);

  localparam int PS = AVERAGE_FRAC_BITS - 16;  // price to average alignment
  localparam int AW = AVERAGE_FRAC_BITS + 16;  // price average width
  localparam int DW = AW + 2;                  // difference width
  localparam int MW = ALPHA_BITS + 2;          // signed alpha width
  localparam int PW = DW + MW;

  function automatic logic [ALPHA_BITS:0] clamp_alpha(input logic [REG_W-1:0] a);
    logic [31:0] wide;
    logic [31:0] one;
    wide = 32'(a);
    one  = 32'(1) << ALPHA_BITS;
    if (wide > one) return one[ALPHA_BITS:0];
    else            return wide[ALPHA_BITS:0];
  endfunction

  logic        [AW-1:0] x_q;
  logic        [AW-1:0] short_q, long_q;
  logic signed [AW:0]   signal_q;
  logic signed [PW-1:0] prod_q;
  mark_e                last_q;
  logic                 seeded_q;

  logic                 out_valid_q;
  logic signed [32:0]   macd_out_q, signal_out_q;
  logic                 buy_q, sell_q;

  logic        [ALPHA_BITS:0] alpha;
  logic signed [DW-1:0]       mul_d;
  logic signed [PW-1:0]       mul_p;
  logic signed [PW-1:0]       prod_sh;
  logic signed [DW-1:0]       term;
  logic signed [DW-1:0]       short_sum, long_sum, signal_sum;
  logic signed [AW:0]         macd, signal_nxt;
  logic                       gt, lt, buy, sell;
  mark_e                      last_d;

  assign macd = $signed({1'b0, short_q}) - $signed({1'b0, long_q});

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SHORT: begin
        alpha = clamp_alpha(short_alpha_i);
        mul_d = $signed({2'b00, x_q}) - $signed({2'b00, short_q});
      end
      MUL_LONG: begin
        alpha = clamp_alpha(long_alpha_i);
        mul_d = $signed({2'b00, x_q}) - $signed({2'b00, long_q});
      end
      MUL_SIGNAL: begin
        alpha = clamp_alpha(signal_alpha_i);
        mul_d = $signed({macd[AW], macd}) - $signed({signal_q[AW], signal_q});
      end
      default: begin
        alpha = '0;
        mul_d = '0;
      end
    endcase
    mul_p = mul_d * $signed({1'b0, alpha});
  end

  assign prod_sh    = prod_q >>> ALPHA_BITS;
  assign term       = prod_sh[DW-1:0];
  assign short_sum  = $signed({2'b00, short_q}) + term;
  assign long_sum   = $signed({2'b00, long_q}) + term;
  assign signal_sum = $signed({signal_q[AW], signal_q}) + term;
  assign signal_nxt = signal_sum[AW:0];

  always_comb begin
    gt     = macd > signal_nxt;
    lt     = macd < signal_nxt;
    buy    = 1'b0;
    sell   = 1'b0;
    last_d = last_q;
    priority if (gt) begin
      if (last_q != MARK_BUY) begin
        buy    = 1'b1;
        last_d = MARK_BUY;
      end
    end else if (lt) begin
      if (last_q != MARK_SELL) begin
        sell   = 1'b1;
        last_d = MARK_SELL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) x_q <= AW'(price_i) << PS;
    if (cmd_i.mul_en) prod_q <= mul_p;
    if (cmd_i.seed) begin
      short_q  <= x_q;
      long_q   <= x_q;
      signal_q <= '0;
    end
    if (cmd_i.upd_short) short_q <= short_sum[AW-1:0];
    if (cmd_i.upd_long) long_q <= long_sum[AW-1:0];
    if (cmd_i.upd_signal) signal_q <= signal_nxt;
    if (cmd_i.load_out) begin
      if (cmd_i.seed) begin
        macd_out_q   <= '0;
        signal_out_q <= '0;
        buy_q        <= 1'b0;
        sell_q       <= 1'b0;
      end else begin
        macd_out_q   <= macd[AW:PS];
        signal_out_q <= signal_nxt[AW:PS];
        buy_q        <= buy;
        sell_q       <= sell;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= MARK_NONE;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.seed) begin
        last_q   <= MARK_NONE;
        seeded_q <= 1'b1;
      end else if (cmd_i.upd_signal) begin
        last_q <= last_d;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.seeded   = seeded_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign macd_value_o   = macd_out_q;
  assign signal_value_o = signal_out_q;
  assign buy_mark_o     = buy_q;
  assign sell_mark_o    = sell_q;

endmodule

`default_nettype wire
